@@ rtl/core/srt_pkg.sv @@
// Package for the sorted region table: payload types, memory entry type,
// compare result type and the operation and status codes. No dependencies.
`default_nettype none

package srt_pkg;

  localparam int AddrW  = 39;
  localparam int FlagW  = 8;
  localparam int CountW = 7;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [FlagW-1:0]  flags_t;
  typedef logic [1:0]        op_t;
  typedef logic [1:0]        status_t;

  localparam op_t OpInsert = 2'd0;
  localparam op_t OpLookup = 2'd1;
  localparam op_t OpClear  = 2'd2;

  localparam status_t StatusOk      = 2'd0;
  localparam status_t StatusEmpty   = 2'd1;
  localparam status_t StatusOverlap = 2'd2;
  localparam status_t StatusFull    = 2'd3;

  typedef struct packed {
    op_t    operation;
    addr_t  region_start;
    addr_t  region_end;
    flags_t region_flags;
    addr_t  lookup_address;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic              found;
    addr_t             hit_start;
    addr_t             hit_end;
    flags_t            hit_flags;
    logic [CountW-1:0] region_count;
  } out_t;

  typedef struct packed {
    addr_t  region_start;
    addr_t  region_end;
    flags_t region_flags;
  } entry_t;

  typedef struct packed {
    logic start_le_key;
    logic key_lt_end;
    logic start_lt_key2;
  } cmp_t;

endpackage

`default_nettype wire

@@ rtl/core/srt_cmp.sv @@
// Shared address compare unit of the sorted region table.
// Depends on srt_pkg for the entry and compare result types.
`default_nettype none

module srt_cmp (
  input  srt_pkg::entry_t entry_i,
  input  srt_pkg::addr_t  key_i,
  input  srt_pkg::addr_t  key2_i,
  output srt_pkg::cmp_t   cmp_o
);

  assign cmp_o.start_le_key  = entry_i.region_start <= key_i;
  assign cmp_o.key_lt_end    = key_i < entry_i.region_end;
  assign cmp_o.start_lt_key2 = entry_i.region_start < key2_i;

endmodule

`default_nettype wire

@@ rtl/core/sorted_region_table_top.sv @@
// Top level of the sorted region table: sequencer, region memory and
// last-hit cache. Depends on srt_pkg and srt_cmp.
//
// The table holds up to MAX_REGIONS non-overlapping half-open regions sorted
// by start, in one memory with a single registered read port and one write
// port. A lookup that hits the last-hit cache is answered without reading the
// memory; otherwise the held entries are read in order until one holds the
// address or all n held regions have been examined. An insert reads the
// entries whose start is not above the new start and the one after them, if
// any, moves the later regions up by one and writes the new region in the
// gap. An empty range is refused before any entry is read; an overlap or a
// full table is refused after the scan. Clear and the unused code go straight
// to the response. One item is worked on at a time; the input is stalled
// until its result has been loaded into the output register, and a stalled
// result holds the next item back.
`default_nettype none

module sorted_region_table_top #(
  parameter int MAX_REGIONS = 64
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  srt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output srt_pkg::out_t  out_data_o
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDecode  = 3'd1;
  localparam logic [2:0] StScan    = 3'd2;
  localparam logic [2:0] StCheck   = 3'd3;
  localparam logic [2:0] StShiftRd = 3'd4;
  localparam logic [2:0] StShiftWr = 3'd5;
  localparam logic [2:0] StPlace   = 3'd6;
  localparam logic [2:0] StResp    = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   j_q, j_d;
  logic [CW-1:0]   j_dec;
  logic [CW-1:0]   count_q, count_d;
  logic            have_prev_q, have_prev_d;
  logic            prev_ovl_q, prev_ovl_d;
  logic            cache_valid_q, cache_valid_d;
  srt_pkg::entry_t cache_q, cache_d;
  srt_pkg::in_t    item_q, item_d;
  srt_pkg::out_t   res_q, res_d;
  srt_pkg::out_t   out_q, out_d;
  logic            out_valid_q, out_valid_d;

  srt_pkg::entry_t mem_q [MAX_REGIONS];
  srt_pkg::entry_t rd_q;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  srt_pkg::entry_t wr_data;

  srt_pkg::entry_t cmp_entry;
  srt_pkg::entry_t key_entry;
  srt_pkg::addr_t  cmp_key;
  srt_pkg::cmp_t   cmp;
  logic            is_full;

  srt_cmp u_cmp (
    .entry_i (cmp_entry),
    .key_i   (cmp_key),
    .key2_i  (item_q.region_end),
    .cmp_o   (cmp)
  );

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign is_full     = count_q >= CW'(MAX_REGIONS);
  assign j_dec       = j_q - CW'(1);
  assign cmp_key     = (item_q.operation == srt_pkg::OpLookup) ?
                       item_q.lookup_address : item_q.region_start;
  assign key_entry   = srt_pkg::entry_t'{region_start: item_q.region_start,
                                         region_end:   '0,
                                         region_flags: '0};
  assign cmp_entry   = (state_q != StDecode) ? rd_q :
                       (item_q.operation == srt_pkg::OpLookup) ? cache_q : key_entry;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    j_d           = j_q;
    count_d       = count_q;
    have_prev_d   = have_prev_q;
    prev_ovl_d    = prev_ovl_q;
    cache_valid_d = cache_valid_q;
    cache_d       = cache_q;
    item_d        = item_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    rd_addr       = idx_q[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_q[IW-1:0];
    wr_data       = '{region_start: item_q.region_start,
                      region_end:   item_q.region_end,
                      region_flags: item_q.region_flags};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = StDecode;
        end
      end
      StDecode: begin
        res_d       = '0;
        idx_d       = '0;
        have_prev_d = 1'b0;
        prev_ovl_d  = 1'b0;
        state_d     = StResp;
        unique case (item_q.operation)
          srt_pkg::OpInsert: begin
            if (!cmp.start_lt_key2) begin
              res_d.status = srt_pkg::StatusEmpty;
            end else begin
              state_d = StScan;
            end
          end
          srt_pkg::OpLookup: begin
            if (cache_valid_q && cmp.start_le_key && cmp.key_lt_end) begin
              res_d.found     = 1'b1;
              res_d.hit_start = cache_q.region_start;
              res_d.hit_end   = cache_q.region_end;
              res_d.hit_flags = cache_q.region_flags;
            end else begin
              state_d = StScan;
            end
          end
          srt_pkg::OpClear: begin
            count_d       = '0;
            cache_valid_d = 1'b0;
            cache_d       = '0;
          end
          default: begin
          end
        endcase
      end
      StScan: begin
        if (idx_q == count_q) begin
          state_d = StResp;
          if (item_q.operation == srt_pkg::OpInsert) begin
            priority if (have_prev_q && prev_ovl_q) begin
              res_d.status = srt_pkg::StatusOverlap;
            end else if (is_full) begin
              res_d.status = srt_pkg::StatusFull;
            end else begin
              j_d     = count_q;
              state_d = StShiftRd;
            end
          end
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (item_q.operation == srt_pkg::OpLookup) begin
          if (cmp.start_le_key && cmp.key_lt_end) begin
            cache_valid_d   = 1'b1;
            cache_d         = rd_q;
            res_d.found     = 1'b1;
            res_d.hit_start = rd_q.region_start;
            res_d.hit_end   = rd_q.region_end;
            res_d.hit_flags = rd_q.region_flags;
            state_d         = StResp;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = StScan;
          end
        end else if (cmp.start_le_key) begin
          prev_ovl_d  = cmp.key_lt_end;
          have_prev_d = 1'b1;
          idx_d       = idx_q + CW'(1);
          state_d     = StScan;
        end else begin
          state_d = StResp;
          priority if ((have_prev_q && prev_ovl_q) || cmp.start_lt_key2) begin
            res_d.status = srt_pkg::StatusOverlap;
          end else if (is_full) begin
            res_d.status = srt_pkg::StatusFull;
          end else begin
            j_d     = count_q;
            state_d = StShiftRd;
          end
        end
      end
      StShiftRd: begin
        if (j_q == idx_q) begin
          state_d = StPlace;
        end else begin
          rd_addr = j_dec[IW-1:0];
          state_d = StShiftWr;
        end
      end
      StShiftWr: begin
        wr_en   = 1'b1;
        wr_addr = j_q[IW-1:0];
        wr_data = rd_q;
        j_d     = j_dec;
        state_d = StShiftRd;
      end
      StPlace: begin
        wr_en        = 1'b1;
        count_d      = count_q + CW'(1);
        res_d.status = srt_pkg::StatusOk;
        state_d      = StResp;
      end
      StResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d              = res_q;
          out_d.region_count = srt_pkg::CountW'(count_q);
          out_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      idx_q         <= '0;
      j_q           <= '0;
      count_q       <= '0;
      have_prev_q   <= 1'b0;
      prev_ovl_q    <= 1'b0;
      cache_valid_q <= 1'b0;
      cache_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      j_q           <= j_d;
      count_q       <= count_d;
      have_prev_q   <= have_prev_d;
      prev_ovl_q    <= prev_ovl_d;
      cache_valid_q <= cache_valid_d;
      cache_q       <= cache_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire
